// ----- sv/gbs_pkg.sv -----
// Shared constants, types and helpers for the GIF block scanner.
`default_nettype none

package gbs_pkg;

  localparam int FRAME_COUNT_BITS = 16;
  localparam int FRAME_OUT_BITS   = 16;
  localparam int SKIP_BITS        = 10;
  localparam int HPOS_BITS        = 4;
  localparam int CHAIN_BITS       = 8;
  localparam int PHASE_BITS       = 4;
  localparam int GCE_BITS         = 2;
  localparam int VERDICT_BITS     = 2;
  localparam int OUT_DATA_BITS    = 24;

  localparam logic [PHASE_BITS-1:0] PH_HEADER   = 4'd0;
  localparam logic [PHASE_BITS-1:0] PH_GCT      = 4'd1;
  localparam logic [PHASE_BITS-1:0] PH_TAG      = 4'd2;
  localparam logic [PHASE_BITS-1:0] PH_LABEL    = 4'd3;
  localparam logic [PHASE_BITS-1:0] PH_EXT_LEN  = 4'd4;
  localparam logic [PHASE_BITS-1:0] PH_EXT_DATA = 4'd5;
  localparam logic [PHASE_BITS-1:0] PH_DESC     = 4'd6;
  localparam logic [PHASE_BITS-1:0] PH_LCT      = 4'd7;
  localparam logic [PHASE_BITS-1:0] PH_LZW      = 4'd8;
  localparam logic [PHASE_BITS-1:0] PH_IMG_LEN  = 4'd9;
  localparam logic [PHASE_BITS-1:0] PH_IMG_DATA = 4'd10;
  localparam logic [PHASE_BITS-1:0] PH_DONE     = 4'd11;

  localparam logic [VERDICT_BITS-1:0] V_UNDECIDED = 2'd0;
  localparam logic [VERDICT_BITS-1:0] V_OK        = 2'd1;
  localparam logic [VERDICT_BITS-1:0] V_BAD       = 2'd2;

  localparam logic [GCE_BITS-1:0] GCE_IDLE  = 2'd0;
  localparam logic [GCE_BITS-1:0] GCE_LABEL = 2'd1;
  localparam logic [GCE_BITS-1:0] GCE_SIZE  = 2'd2;
  localparam logic [GCE_BITS-1:0] GCE_DISP  = 2'd3;

  localparam logic [7:0] TAG_TRAILER   = 8'h3B;
  localparam logic [7:0] TAG_PAD       = 8'h00;
  localparam logic [7:0] TAG_EXTENSION = 8'h21;
  localparam logic [7:0] TAG_IMAGE     = 8'h2C;
  localparam logic [7:0] LABEL_GCE     = 8'hF9;
  localparam logic [7:0] GCE_SIZE_VAL  = 8'd4;
  localparam logic [2:0] DISPOSAL_PREV = 3'd3;

  localparam logic [HPOS_BITS-1:0] HDR_FLAGS_POS = 4'd10;
  localparam logic [HPOS_BITS-1:0] HDR_LAST_POS  = 4'd12;
  localparam logic [SKIP_BITS-1:0] DESC_LAST_POS = 10'd8;

  localparam logic [FRAME_COUNT_BITS-1:0] FRAME_MAX = {FRAME_COUNT_BITS{1'b1}};

  typedef struct packed {
    logic                      status;
    logic [FRAME_OUT_BITS-1:0] image_total;
    logic                      keep_prior;
  } result_t;

  function automatic logic [SKIP_BITS-1:0] table_bytes(input logic [7:0] flags);
    logic [SKIP_BITS-1:0] base;
    base = SKIP_BITS'(2) << flags[2:0];
    if (!flags[7]) begin
      return '0;
    end
    return (base << 1) + base;
  endfunction

endpackage

`default_nettype wire

// ----- sv/gbs_walker.sv -----
// Block-structure state machine: one byte of the file per advance.
`default_nettype none

module gbs_walker (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            advance,
  input  wire logic [7:0]      data_byte,
  input  wire logic            last,
  output gbs_pkg::result_t     res
);

  logic [gbs_pkg::PHASE_BITS-1:0]       phase_r, phase_nxt;
  logic [gbs_pkg::SKIP_BITS-1:0]        skip_r, skip_nxt;
  logic [gbs_pkg::HPOS_BITS-1:0]        hpos_r, hpos_nxt;
  logic [gbs_pkg::CHAIN_BITS-1:0]       chain_r, chain_nxt;
  logic [gbs_pkg::GCE_BITS-1:0]         gce_r, gce_nxt;
  logic [gbs_pkg::FRAME_COUNT_BITS-1:0] frames_r, frames_nxt;
  logic                                 hist_r, hist_nxt;
  logic [gbs_pkg::VERDICT_BITS-1:0]     verdict_r, verdict_nxt;
  logic [gbs_pkg::SKIP_BITS-1:0]        tbl;
  logic [31:0]                          frames_ext;

  assign tbl = gbs_pkg::table_bytes(data_byte);

  always_comb begin
    phase_nxt   = phase_r;
    skip_nxt    = skip_r;
    hpos_nxt    = hpos_r;
    chain_nxt   = chain_r;
    gce_nxt     = gce_r;
    frames_nxt  = frames_r;
    hist_nxt    = hist_r;
    verdict_nxt = verdict_r;
    case (phase_r)
      gbs_pkg::PH_HEADER: begin
        if (hpos_r == gbs_pkg::HDR_FLAGS_POS) begin
          skip_nxt = tbl;
        end
        if (hpos_r >= gbs_pkg::HDR_LAST_POS) begin
          hpos_nxt  = '0;
          phase_nxt = (skip_nxt != '0) ? gbs_pkg::PH_GCT : gbs_pkg::PH_TAG;
        end else begin
          hpos_nxt = hpos_r + 1'b1;
        end
      end
      gbs_pkg::PH_GCT, gbs_pkg::PH_LCT: begin
        if (skip_r != '0) begin
          skip_nxt = skip_r - 1'b1;
        end
        if (skip_nxt == '0) begin
          phase_nxt = (phase_r == gbs_pkg::PH_GCT) ? gbs_pkg::PH_TAG : gbs_pkg::PH_LZW;
        end
      end
      gbs_pkg::PH_TAG: begin
        case (data_byte)
          gbs_pkg::TAG_TRAILER: begin
            verdict_nxt = gbs_pkg::V_OK;
            phase_nxt   = gbs_pkg::PH_DONE;
          end
          gbs_pkg::TAG_PAD: begin
          end
          gbs_pkg::TAG_EXTENSION: begin
            phase_nxt = gbs_pkg::PH_LABEL;
          end
          gbs_pkg::TAG_IMAGE: begin
            skip_nxt  = '0;
            phase_nxt = gbs_pkg::PH_DESC;
          end
          default: begin
            verdict_nxt = gbs_pkg::V_BAD;
            phase_nxt   = gbs_pkg::PH_DONE;
          end
        endcase
      end
      gbs_pkg::PH_LABEL: begin
        gce_nxt   = (data_byte == gbs_pkg::LABEL_GCE) ? gbs_pkg::GCE_LABEL : gbs_pkg::GCE_IDLE;
        phase_nxt = gbs_pkg::PH_EXT_LEN;
      end
      gbs_pkg::PH_EXT_LEN, gbs_pkg::PH_IMG_LEN: begin
        if (data_byte == 8'd0) begin
          gce_nxt = gbs_pkg::GCE_IDLE;
          if (phase_r == gbs_pkg::PH_IMG_LEN && frames_r != gbs_pkg::FRAME_MAX) begin
            frames_nxt = frames_r + 1'b1;
          end
          phase_nxt = gbs_pkg::PH_TAG;
        end else begin
          if (gce_r == gbs_pkg::GCE_LABEL) begin
            gce_nxt = (data_byte == gbs_pkg::GCE_SIZE_VAL) ? gbs_pkg::GCE_SIZE
                                                           : gbs_pkg::GCE_IDLE;
          end
          chain_nxt = data_byte;
          phase_nxt = (phase_r == gbs_pkg::PH_EXT_LEN) ? gbs_pkg::PH_EXT_DATA
                                                       : gbs_pkg::PH_IMG_DATA;
        end
      end
      gbs_pkg::PH_EXT_DATA, gbs_pkg::PH_IMG_DATA: begin
        if (gce_r == gbs_pkg::GCE_SIZE) begin
          gce_nxt = (data_byte[4:2] == gbs_pkg::DISPOSAL_PREV) ? gbs_pkg::GCE_DISP
                                                                : gbs_pkg::GCE_IDLE;
        end
        if (chain_r != '0) begin
          chain_nxt = chain_r - 1'b1;
        end
        if (chain_nxt == '0) begin
          if (gce_nxt == gbs_pkg::GCE_DISP) begin
            hist_nxt = 1'b1;
          end
          gce_nxt   = gbs_pkg::GCE_IDLE;
          phase_nxt = (phase_r == gbs_pkg::PH_EXT_DATA) ? gbs_pkg::PH_EXT_LEN
                                                        : gbs_pkg::PH_IMG_LEN;
        end
      end
      gbs_pkg::PH_DESC: begin
        if (skip_r >= gbs_pkg::DESC_LAST_POS) begin
          skip_nxt  = tbl;
          phase_nxt = (tbl != '0) ? gbs_pkg::PH_LCT : gbs_pkg::PH_LZW;
        end else begin
          skip_nxt = skip_r + 1'b1;
        end
      end
      gbs_pkg::PH_LZW: begin
        phase_nxt = gbs_pkg::PH_IMG_LEN;
      end
      default: begin
      end
    endcase
  end

  assign frames_ext      = 32'(frames_nxt);
  assign res.status      = (verdict_nxt != gbs_pkg::V_OK);
  assign res.image_total = frames_ext[gbs_pkg::FRAME_OUT_BITS-1:0];
  assign res.keep_prior  = hist_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (advance && last)) begin
      phase_r   <= gbs_pkg::PH_HEADER;
      skip_r    <= '0;
      hpos_r    <= '0;
      chain_r   <= '0;
      gce_r     <= gbs_pkg::GCE_IDLE;
      frames_r  <= '0;
      hist_r    <= 1'b0;
      verdict_r <= gbs_pkg::V_UNDECIDED;
    end else if (advance) begin
      phase_r   <= phase_nxt;
      skip_r    <= skip_nxt;
      hpos_r    <= hpos_nxt;
      chain_r   <= chain_nxt;
      gce_r     <= gce_nxt;
      frames_r  <= frames_nxt;
      hist_r    <= hist_nxt;
      verdict_r <= verdict_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/gbs_out_reg.sv -----
// Result register for the scanner's verdict channel.
`default_nettype none

module gbs_out_reg (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 load,
  input  gbs_pkg::result_t                          res,
  output logic                                      busy,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [gbs_pkg::OUT_DATA_BITS-1:0]         out_tdata
);

  logic             valid_r, valid_nxt;
  gbs_pkg::result_t res_r;

  assign busy = valid_r && !out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_tready) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = gbs_pkg::OUT_DATA_BITS'({res_r.keep_prior, res_r.image_total,
                                               res_r.status});

endmodule

`default_nettype wire

// ----- sv/gif_block_scanner.sv -----
// Top level of the GIF block-structure scanner.
//
// The input channel carries the file one byte per transfer: in_tdata holds
// the byte, in_tlast marks the final byte of the file. Bytes are taken at one
// per clock while no last byte is held back. Each byte lands in an input
// register, then next-state logic updates the block walker. The byte marked last
// also loads the result register, and the walker returns to its reset state for
// the next file. One result per file: the last byte goes from the input register
// into the result register, which raises out_tvalid for the result transfer:
// status (0 trailer reached, 1 malformed or truncated), the saturating count
// of completed images, and the history flag.
// Bytes without tlast keep flowing while a result waits; a last byte is held
// in the input register only while the previous result is still untaken, and
// in_tready drops until the receiver takes it.
// Reset (rst_n low, synchronous) empties both registers and puts the walker at
// the start of the header.
`default_nettype none

module gif_block_scanner (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [7:0]                         in_tdata,  // [7:0] data_byte
  input  wire logic                               in_tlast,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [0] status, [16:1] image_total, [17] keep_prior, [23:18] zero
  output logic [gbs_pkg::OUT_DATA_BITS-1:0]       out_tdata
);

  logic             full_r, full_nxt;
  logic [7:0]       byte_r;
  logic             last_r;
  logic             advance;
  logic             out_busy;
  gbs_pkg::result_t res;

  assign advance   = full_r && !(last_r && out_busy);
  assign in_tready = !full_r || advance;

  always_comb begin
    full_nxt = full_r;
    if (advance) begin
      full_nxt = 1'b0;
    end
    if (in_tvalid && in_tready) begin
      full_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  gbs_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .data_byte (byte_r),
    .last      (last_r),
    .res       (res)
  );

  gbs_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && last_r),
    .res        (res),
    .busy       (out_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ----- sv/gbs_checker.sv -----
// Port-level checks for the GIF block scanner, bound to the top level.
`default_nettype none

module gbs_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tvalid,
  input wire logic                               in_tready,
  input wire logic                               in_tlast,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [gbs_pkg::OUT_DATA_BITS-1:0]  out_tdata
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[gbs_pkg::OUT_DATA_BITS-1:18] == '0)
    else $error("pad bits of result not zero");

  a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast, 2))
    else $error("result without a last-byte transfer two cycles earlier");

endmodule

bind gif_block_scanner gbs_checker u_gbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ----- test/tb.sv -----
// Testbench for gif_block_scanner: random GIF byte streams checked against a block-walk predictor.
`timescale 1ns / 1ps

module tb;
  import gbs_pkg::*;

  typedef struct {
    logic [7:0] data_byte;
    logic       last;
  } gif_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;

  gif_byte_t bytes_to_send[$];
  logic [7:0] file_bytes[$];
  result_t scan_results_due[$];
  gif_byte_t next_byte;
  result_t due_result;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int items_queued = 0;
  int files_queued = 0;
  bit in_taken = 1'b0;

  logic [PHASE_BITS-1:0]       scan_phase;
  logic [SKIP_BITS-1:0]        skip_left;
  logic [HPOS_BITS-1:0]        header_idx;
  logic [CHAIN_BITS-1:0]       chain_left;
  logic [GCE_BITS-1:0]         gce_state;
  logic [FRAME_COUNT_BITS-1:0] frame_tally;
  logic                        history_seen;
  logic [VERDICT_BITS-1:0]     scan_verdict;

  gif_block_scanner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),  // [7:0] data_byte
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)  // [0] status, [16:1] image_total, [17] keep_prior, [23:18] zero
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [SKIP_BITS-1:0] table_size(input logic [7:0] flags);
    if (!flags[7]) begin
      return '0;
    end
    return SKIP_BITS'(3 * (2 << flags[2:0]));
  endfunction

  task automatic clear_scan_state();
    scan_phase   = PH_HEADER;
    skip_left    = '0;
    header_idx   = '0;
    chain_left   = '0;
    gce_state    = GCE_IDLE;
    frame_tally  = '0;
    history_seen = 1'b0;
    scan_verdict = V_UNDECIDED;
  endtask

  task automatic advance_scan(input logic [7:0] b);
    case (scan_phase)
      PH_HEADER: begin
        if (header_idx == HDR_FLAGS_POS) skip_left = table_size(b);
        if (header_idx >= HDR_LAST_POS) begin
          header_idx = '0;
          scan_phase = (skip_left != 0) ? PH_GCT : PH_TAG;
        end else begin
          header_idx = header_idx + 1'b1;
        end
      end
      PH_GCT, PH_LCT: begin
        if (skip_left != 0) skip_left = skip_left - 1'b1;
        if (skip_left == 0) scan_phase = (scan_phase == PH_GCT) ? PH_TAG : PH_LZW;
      end
      PH_TAG: begin
        if (b == TAG_TRAILER) begin
          scan_verdict = V_OK;
          scan_phase = PH_DONE;
        end else if (b == TAG_PAD) begin
          scan_phase = PH_TAG;
        end else if (b == TAG_EXTENSION) begin
          scan_phase = PH_LABEL;
        end else if (b == TAG_IMAGE) begin
          skip_left = '0;
          scan_phase = PH_DESC;
        end else begin
          scan_verdict = V_BAD;
          scan_phase = PH_DONE;
        end
      end
      PH_LABEL: begin
        gce_state = (b == LABEL_GCE) ? GCE_LABEL : GCE_IDLE;
        scan_phase = PH_EXT_LEN;
      end
      PH_EXT_LEN, PH_IMG_LEN: begin
        if (b == 8'h00) begin
          gce_state = GCE_IDLE;
          if (scan_phase == PH_IMG_LEN && frame_tally != FRAME_MAX)
            frame_tally = frame_tally + 1'b1;
          scan_phase = PH_TAG;
        end else begin
          if (gce_state == GCE_LABEL) gce_state = (b == GCE_SIZE_VAL) ? GCE_SIZE : GCE_IDLE;
          chain_left = b;
          scan_phase = (scan_phase == PH_EXT_LEN) ? PH_EXT_DATA : PH_IMG_DATA;
        end
      end
      PH_EXT_DATA, PH_IMG_DATA: begin
        if (gce_state == GCE_SIZE) gce_state = (b[4:2] == DISPOSAL_PREV) ? GCE_DISP : GCE_IDLE;
        if (chain_left != 0) chain_left = chain_left - 1'b1;
        if (chain_left == 0) begin
          if (gce_state == GCE_DISP) history_seen = 1'b1;
          gce_state = GCE_IDLE;
          scan_phase = (scan_phase == PH_EXT_DATA) ? PH_EXT_LEN : PH_IMG_LEN;
        end
      end
      PH_DESC: begin
        if (skip_left >= DESC_LAST_POS) begin
          skip_left = table_size(b);
          scan_phase = (skip_left != 0) ? PH_LCT : PH_LZW;
        end else begin
          skip_left = skip_left + 1'b1;
        end
      end
      PH_LZW: scan_phase = PH_IMG_LEN;
      default: scan_phase = scan_phase;
    endcase
  endtask

  task automatic walk_gif_byte(input logic [7:0] b, input logic is_last);
    result_t r;
    if (scan_phase != PH_DONE) advance_scan(b);
    if (is_last) begin
      if (scan_verdict == V_UNDECIDED) scan_verdict = V_BAD;
      r.status      = (scan_verdict != V_OK);
      r.image_total = frame_tally[FRAME_OUT_BITS-1:0];
      r.keep_prior  = history_seen;
      scan_results_due.push_back(r);
      clear_scan_state();
    end
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (!in_tvalid || in_taken) begin
        if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_byte = bytes_to_send.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_byte.data_byte;
          in_tlast  <= next_byte.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (scan_results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result transfer: tdata %h", out_tdata);
      end else begin
        due_result = scan_results_due.pop_front();
        if (out_tdata[0] !== due_result.status ||
            out_tdata[16:1] !== due_result.image_total ||
            out_tdata[17] !== due_result.keep_prior || out_tdata[23:18] !== 6'd0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"result mismatch: expected status %0d frames %0d history %0d, ",
                      "got %0d %0d %0d pad %h"},
                     due_result.status, due_result.image_total, due_result.keep_prior,
                     out_tdata[0], out_tdata[16:1], out_tdata[17], out_tdata[23:18]);
        end
      end
    end
    if (rst_n && in_tvalid && in_tready) walk_gif_byte(in_tdata, in_tlast);
    in_taken = rst_n && in_tvalid && in_tready;
  end

  task automatic queue_file();
    gif_byte_t item;
    for (int i = 0; i < file_bytes.size(); i++) begin
      item.data_byte = file_bytes[i];
      item.last = (i == file_bytes.size() - 1);
      bytes_to_send.push_back(item);
    end
    items_queued += file_bytes.size();
    files_queued++;
  endtask

  function automatic logic [7:0] random_table_flags();
    logic [7:0] f;
    f = 8'($urandom_range(255));
    f[2:0] = ($urandom_range(49) == 0) ? 3'd7 : 3'($urandom_range(1));
    return f;
  endfunction

  task automatic add_table(input logic [7:0] flags);
    if (flags[7]) repeat (3 * (2 << flags[2:0])) file_bytes.push_back(8'($urandom_range(255)));
  endtask

  task automatic add_chain(input int n_blocks);
    int len;
    for (int i = 0; i < n_blocks; i++) begin
      len = ($urandom_range(29) == 0) ? 255 : $urandom_range(1, 6);
      file_bytes.push_back(8'(len));
      repeat (len) file_bytes.push_back(8'($urandom_range(255)));
    end
    file_bytes.push_back(8'h00);
  endtask

  task automatic add_block();
    int pick;
    logic [7:0] flags;
    pick = $urandom_range(9);
    if (pick < 2) begin
      file_bytes.push_back(TAG_PAD);
    end else if (pick < 5) begin
      file_bytes.push_back(TAG_EXTENSION);
      if ($urandom_range(1)) begin
        file_bytes.push_back(LABEL_GCE);
        if ($urandom_range(3) != 0) begin
          file_bytes.push_back(GCE_SIZE_VAL);
          flags = 8'($urandom_range(255));
          if ($urandom_range(1)) flags[4:2] = DISPOSAL_PREV;
          file_bytes.push_back(flags);
          repeat (3) file_bytes.push_back(8'($urandom_range(255)));
          add_chain($urandom_range(0, 1));
        end else begin
          add_chain($urandom_range(0, 2));
        end
      end else begin
        file_bytes.push_back(8'($urandom_range(255)));
        add_chain($urandom_range(0, 2));
      end
    end else begin
      file_bytes.push_back(TAG_IMAGE);
      repeat (8) file_bytes.push_back(8'($urandom_range(255)));
      flags = random_table_flags();
      file_bytes.push_back(flags);
      add_table(flags);
      file_bytes.push_back(8'($urandom_range(255)));
      add_chain($urandom_range(0, 2));
    end
  endtask

  task automatic compose_gif();
    int kind;
    logic [7:0] flags;
    logic [7:0] bad_tag;
    file_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 20) begin
      repeat ($urandom_range(1, 16)) file_bytes.push_back(8'($urandom_range(255)));
    end else begin
      flags = random_table_flags();
      for (int i = 0; i < 13; i++)
        file_bytes.push_back((i == 10) ? flags : 8'($urandom_range(255)));
      add_table(flags);
      repeat ($urandom_range(0, 4)) add_block();
      if (kind < 32) begin
        do bad_tag = 8'($urandom_range(255));
        while (bad_tag == TAG_PAD || bad_tag == TAG_EXTENSION || bad_tag == TAG_IMAGE ||
               bad_tag == TAG_TRAILER);
        file_bytes.push_back(bad_tag);
      end else begin
        file_bytes.push_back(TAG_TRAILER);
      end
      if ($urandom_range(2) == 0)
        repeat ($urandom_range(1, 3)) file_bytes.push_back(8'($urandom_range(255)));
      if (kind >= 80) begin
        kind = $urandom_range(1, file_bytes.size() - 1);
        while (file_bytes.size() > kind) void'(file_bytes.pop_back());
      end
    end
  endtask

  task automatic queue_random_files(input int byte_budget, input int file_floor);
    int bytes_start;
    int files_start;
    bytes_start = items_queued;
    files_start = files_queued;
    while (items_queued - bytes_start < byte_budget || files_queued - files_start < file_floor) begin
      compose_gif();
      queue_file();
    end
  endtask

  task automatic wait_for_results();
    while (bytes_to_send.size() != 0 || in_tvalid || scan_results_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    clear_scan_state();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 21;
    recv_idle_pct = 53;
    file_bytes.delete();
    file_bytes.push_back(8'hFF);
    queue_file();
    file_bytes.delete();
    repeat (13) file_bytes.push_back(8'h00);
    file_bytes.push_back(TAG_PAD);
    file_bytes.push_back(TAG_TRAILER);
    file_bytes.push_back(8'hFF);
    queue_file();
    file_bytes.delete();
    file_bytes.push_back(8'h00);
    queue_file();
    queue_random_files(530, 0);
    wait_for_results();

    send_idle_pct = 53;
    recv_idle_pct = 21;
    queue_random_files(530, 0);
    wait_for_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_files(530, 0);
    wait_for_results();

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && scan_results_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
